// ===== hw/rtl/bcp_pkg.sv =====
// Shared types, constants and microprogram of the balance cascade controller.
`default_nettype none

package bcp_pkg;

   localparam int ACC_W   = 48;
   localparam int MA_W    = 32;
   localparam int MB_W    = 21;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int PC_W    = 4;
   localparam int FILT_W  = 27;
   localparam int INTEG_W = 25;
   localparam int LAST_W  = 19;
   localparam int SE_W    = 18;
   localparam int DIFF_W  = 20;
   localparam int ERR_W   = 14;
   localparam int DRV_W   = 15;
   localparam int CSR_W   = 17;
   localparam int IDX_W   = 3;

   localparam int DRIVE_LIMIT    = 8400;
   localparam int FALL_LIMIT     = 7680;
   localparam int BOOST_LIMIT    = 4608;
   localparam int DEAD_ZONE      = 25;
   localparam int BOOST_Q10      = 1946;
   localparam int FILT_KEEP_Q10  = 819;
   localparam int FILT_NEW_Q10   = 205;
   localparam int INTEG_LIMIT_Q8 = 15360000;
   localparam int FORWARD_LIMIT  = 60000;

   localparam logic [IDX_W-1:0] REG_ANGLE_TARGET = 3'd0;
   localparam logic [IDX_W-1:0] REG_ANGLE_P_GAIN = 3'd1;
   localparam logic [IDX_W-1:0] REG_ANGLE_D_GAIN = 3'd2;
   localparam logic [IDX_W-1:0] REG_SPEED_TARGET = 3'd3;
   localparam logic [IDX_W-1:0] REG_SPEED_P_GAIN = 3'd4;
   localparam logic [IDX_W-1:0] REG_SPEED_I_GAIN = 3'd5;
   localparam logic [IDX_W-1:0] REG_SPEED_D_GAIN = 3'd6;

   localparam logic [1:0] TURN_LEFT    = 2'd1;
   localparam logic [1:0] TURN_RIGHT   = 2'd2;
   localparam logic [1:0] FWD_FORWARD  = 2'd0;
   localparam logic [1:0] FWD_BACKWARD = 2'd1;

   // multiplier operand pairs
   localparam logic [3:0] MS_NONE    = 4'd0;
   localparam logic [3:0] MS_F819    = 4'd1;
   localparam logic [3:0] MS_SE205   = 4'd2;
   localparam logic [3:0] MS_EP      = 4'd3;
   localparam logic [3:0] MS_GD      = 4'd4;
   localparam logic [3:0] MS_SESP    = 4'd5;
   localparam logic [3:0] MS_INSI    = 4'd6;
   localparam logic [3:0] MS_DFSD    = 4'd7;
   localparam logic [3:0] MS_PE1946  = 4'd8;

   localparam logic [1:0] ACC_NOP  = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;
   localparam logic [1:0] ACC_SUB  = 2'd3;

   localparam logic [1:0] SH_NONE  = 2'd0;
   localparam logic [1:0] SH_SHL8  = 2'd1;
   localparam logic [1:0] SH_SAR10 = 2'd2;

   localparam logic [1:0] MISC_NOP   = 2'd0;
   localparam logic [1:0] MISC_FILT  = 2'd1;
   localparam logic [1:0] MISC_SPEED = 2'd2;
   localparam logic [1:0] MISC_OUT   = 2'd3;

   localparam logic [1:0] JMP_NONE   = 2'd0;
   localparam logic [1:0] JMP_ALWAYS = 2'd1;
   localparam logic [1:0] JMP_BOOST  = 2'd2;

   localparam logic [PC_W-1:0] UA_ANGLE_TAIL = 4'd7;
   localparam logic [PC_W-1:0] UA_BOOST      = 4'd12;

   typedef struct packed {
      logic [3:0]      msel;
      logic [1:0]      acc_op;
      logic [1:0]      shf;
      logic [1:0]      misc;
      logic [1:0]      jmp;
      logic [PC_W-1:0] target;
      logic            last;
   } ucode_type;

   typedef struct packed {
      logic       fire;
      logic [3:0] msel;
      logic [1:0] acc_op;
      logic [1:0] shf;
      logic [1:0] misc;
   } ctrl_type;

   typedef struct packed {
      logic boost;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic signed [13:0] angle_target;
      logic [15:0]        angle_p_gain;
      logic [15:0]        angle_d_gain;
      logic signed [16:0] speed_target;
      logic [15:0]        speed_p_gain;
      logic [15:0]        speed_i_gain;
      logic [15:0]        speed_d_gain;
   } cfg_type;

   function automatic ucode_type uword(logic [3:0] msel, logic [1:0] acc_op, logic [1:0] shf,
                                       logic [1:0] misc, logic [1:0] jmp,
                                       logic [PC_W-1:0] target, logic last);
      ucode_type w;
      w.msel   = msel;
      w.acc_op = acc_op;
      w.shf    = shf;
      w.misc   = misc;
      w.jmp    = jmp;
      w.target = target;
      w.last   = last;
      return w;
   endfunction

   // acc ops act on the product issued by the previous step
   function automatic ucode_type ucode_rom(logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         4'd0:  w = uword(MS_F819,   ACC_NOP,  SH_NONE,  MISC_NOP,   JMP_NONE,   '0, 1'b0);
         4'd1:  w = uword(MS_SE205,  ACC_LOAD, SH_NONE,  MISC_NOP,   JMP_NONE,   '0, 1'b0);
         4'd2:  w = uword(MS_NONE,   ACC_ADD,  SH_SHL8,  MISC_NOP,   JMP_NONE,   '0, 1'b0);
         4'd3:  w = uword(MS_NONE,   ACC_NOP,  SH_NONE,  MISC_FILT,  JMP_NONE,   '0, 1'b0);
         4'd4:  w = uword(MS_NONE,   ACC_NOP,  SH_NONE,  MISC_SPEED, JMP_NONE,   '0, 1'b0);
         4'd5:  w = uword(MS_EP,     ACC_NOP,  SH_NONE,  MISC_NOP,   JMP_BOOST,
                          UA_BOOST, 1'b0);
         4'd6:  w = uword(MS_GD,     ACC_LOAD, SH_NONE,  MISC_NOP,   JMP_NONE,   '0, 1'b0);
         4'd7:  w = uword(MS_SESP,   ACC_SUB,  SH_NONE,  MISC_NOP,   JMP_NONE,   '0, 1'b0);
         4'd8:  w = uword(MS_INSI,   ACC_ADD,  SH_SHL8,  MISC_NOP,   JMP_NONE,   '0, 1'b0);
         4'd9:  w = uword(MS_DFSD,   ACC_ADD,  SH_NONE,  MISC_NOP,   JMP_NONE,   '0, 1'b0);
         4'd10: w = uword(MS_NONE,   ACC_SUB,  SH_SHL8,  MISC_NOP,   JMP_NONE,   '0, 1'b0);
         4'd11: w = uword(MS_NONE,   ACC_NOP,  SH_NONE,  MISC_OUT,   JMP_NONE,   '0, 1'b1);
         4'd12: w = uword(MS_PE1946, ACC_NOP,  SH_NONE,  MISC_NOP,   JMP_NONE,   '0, 1'b0);
         4'd13: w = uword(MS_GD,     ACC_LOAD, SH_SAR10, MISC_NOP,   JMP_ALWAYS,
                          UA_ANGLE_TAIL, 1'b0);
         default: w = uword(MS_NONE, ACC_NOP,  SH_NONE,  MISC_NOP,   JMP_NONE,   '0, 1'b1);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bcp_useq.sv =====
// Microprogram sequencer: step counter, control store and jumps.
`default_nettype none

module bcp_useq
   import bcp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            start,
   input  wire status_type status,
   output ctrl_type        ctrl
);

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       cw;
   logic            stall;
   logic            take;
   logic            jump;

   assign req_ready = !busy_ff;
   assign start     = req_valid && !busy_ff;

   always_comb begin
      cw    = ucode_rom(pc_ff);
      stall = (cw.misc == MISC_OUT) && !status.out_free;
      take  = busy_ff && !stall;
      jump  = (cw.jmp == JMP_ALWAYS) || ((cw.jmp == JMP_BOOST) && status.boost);
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (take) begin
         if (cw.last) begin
            busy_in = 1'b0;
         end else begin
            pc_in = jump ? cw.target : pc_ff + PC_W'(1);
         end
      end
      ctrl.fire   = take;
      ctrl.msel   = cw.msel;
      ctrl.acc_op = cw.acc_op;
      ctrl.shf    = cw.shf;
      ctrl.misc   = cw.misc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bcp_datapath.sv =====
// Datapath: request capture, shared multiplier, accumulator, loop state and result register.
`default_nettype none

module bcp_datapath
   import bcp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               start,
   input  wire logic signed [16:0] req_pitch_angle,
   input  wire logic signed [19:0] req_gyro_rate,
   input  wire logic signed [15:0] req_left_count,
   input  wire logic signed [15:0] req_right_count,
   input  wire logic [1:0]         req_turn_mode,
   input  wire logic [13:0]        req_turn_amount,
   input  wire logic [1:0]         req_forward_mode,
   input  wire logic [15:0]        req_forward_amount,
   input  wire ctrl_type           ctrl,
   output status_type              status,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [DRV_W-1:0] rsp_left_drive,
   output logic signed [DRV_W-1:0] rsp_right_drive,
   output logic                    rsp_fallen
);

   // request capture
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic                      fallen_ff, fallen_in;
   logic                      boost_ff, boost_in;
   logic                      pfall_ff, pfall_in;
   logic signed [19:0]        gyro_ff, gyro_in;
   logic signed [SE_W-1:0]    se_ff, se_in;
   logic [1:0]                tmode_ff, tmode_in;
   logic [13:0]               tamt_ff, tamt_in;
   logic [1:0]                fmode_ff, fmode_in;
   logic [15:0]               famt_ff, famt_in;
   // loop state
   logic signed [FILT_W-1:0]  filt_ff, filt_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [LAST_W-1:0]  last_ff, last_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   // arithmetic
   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   addend;
   // result
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DRV_W-1:0]   left_ff, left_in;
   logic signed [DRV_W-1:0]   right_ff, right_in;
   logic                      rfallen_ff, rfallen_in;

   logic signed [17:0]        e_full;
   logic signed [SE_W-1:0]    se_now;
   logic                      pfall_now;
   logic signed [INTEG_W+2:0] integ_sum;
   logic signed [INTEG_W-1:0] integ_sat;
   logic signed [SE_W-1:0]    se_z;
   logic signed [29:0]        base;
   logic signed [30:0]        tamt_s;
   logic signed [30:0]        left_pre, right_pre;
   logic [15:0]               famt_eff;
   logic signed [INTEG_W-1:0] famt_q8;

   function automatic logic signed [DRV_W-1:0] sat_drive(logic signed [30:0] x);
      logic signed [DRV_W-1:0] r;
      if (x > 31'sd8400) begin
         r = DRV_W'(DRIVE_LIMIT);
      end else if (x < -31'sd8400) begin
         r = -DRV_W'(DRIVE_LIMIT);
      end else begin
         r = x[DRV_W-1:0];
      end
      return r;
   endfunction

   assign status.boost    = boost_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // capture and per-tick flags
   always_comb begin
      e_full    = 18'(cfg.angle_target) - 18'(req_pitch_angle);
      se_now    = SE_W'(req_left_count) + SE_W'(req_right_count) - SE_W'(cfg.speed_target);
      pfall_now = (req_pitch_angle > 17'sd7680) || (req_pitch_angle < -17'sd7680);
      fallen_in = (e_full > 18'sd7680) || (e_full < -18'sd7680);
      if (fallen_in || ((e_full <= 18'sd25) && (e_full >= -18'sd25))) begin
         err_in = '0;
      end else begin
         err_in = e_full[ERR_W-1:0];
      end
      boost_in = !fallen_in && ((e_full > 18'sd4608) || (e_full < -18'sd4608));
      pfall_in = pfall_now;
      gyro_in  = req_gyro_rate;
      tmode_in = req_turn_mode;
      tamt_in  = fallen_in ? 14'd0 : req_turn_amount;
      fmode_in = req_forward_mode;
      famt_in  = fallen_in ? 16'd0 : req_forward_amount;
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.msel)
         MS_F819: begin
            mul_a = MA_W'(filt_ff);
            mul_b = MB_W'(FILT_KEEP_Q10);
         end
         MS_SE205: begin
            mul_a = MA_W'(se_ff);
            mul_b = MB_W'(FILT_NEW_Q10);
         end
         MS_EP: begin
            mul_a = MA_W'(err_ff);
            mul_b = {5'b0, cfg.angle_p_gain};
         end
         MS_GD: begin
            mul_a = MA_W'(gyro_ff);
            mul_b = {5'b0, cfg.angle_d_gain};
         end
         MS_SESP: begin
            mul_a = MA_W'(se_ff);
            mul_b = {5'b0, cfg.speed_p_gain};
         end
         MS_INSI: begin
            mul_a = MA_W'(integ_ff);
            mul_b = {5'b0, cfg.speed_i_gain};
         end
         MS_DFSD: begin
            mul_a = MA_W'(diff_ff);
            mul_b = {5'b0, cfg.speed_d_gain};
         end
         MS_PE1946: begin
            mul_a = prod_ff[MA_W-1:0];
            mul_b = MB_W'(BOOST_Q10);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // accumulator
   always_comb begin
      case (ctrl.shf)
         SH_SHL8:  addend = ACC_W'(prod_ff) <<< 8;
         SH_SAR10: addend = ACC_W'(prod_ff >>> 10);
         default:  addend = ACC_W'(prod_ff);
      endcase
      acc_in = acc_ff;
      if (ctrl.fire) begin
         unique case (ctrl.acc_op)
            ACC_LOAD: acc_in = addend;
            ACC_ADD:  acc_in = acc_ff + addend;
            ACC_SUB:  acc_in = acc_ff - addend;
            default:  acc_in = acc_ff;
         endcase
      end
   end

   // loop state and result
   always_comb begin
      integ_sum = (INTEG_W+3)'(integ_ff) + (INTEG_W+3)'(filt_ff);
      if (integ_sum > (INTEG_W+3)'(INTEG_LIMIT_Q8)) begin
         integ_sat = INTEG_W'(INTEG_LIMIT_Q8);
      end else if (integ_sum < -(INTEG_W+3)'(INTEG_LIMIT_Q8)) begin
         integ_sat = -INTEG_W'(INTEG_LIMIT_Q8);
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end
      se_z = pfall_ff ? '0 : se_ff;

      base      = acc_ff[ACC_W-1:18];
      tamt_s    = $signed({17'b0, tamt_ff});
      left_pre  = 31'(base);
      right_pre = 31'(base);
      if (tmode_ff == TURN_LEFT) begin
         left_pre  = 31'(base) - tamt_s;
         right_pre = 31'(base) + tamt_s;
      end else if (tmode_ff == TURN_RIGHT) begin
         left_pre  = 31'(base) + tamt_s;
         right_pre = 31'(base) - tamt_s;
      end
      famt_eff = (famt_ff > 16'(FORWARD_LIMIT)) ? 16'(FORWARD_LIMIT) : famt_ff;
      famt_q8  = $signed({1'b0, famt_eff, 8'b0});

      filt_in      = filt_ff;
      integ_in     = integ_ff;
      last_in      = last_ff;
      diff_in      = diff_ff;
      se_in        = start ? se_now : se_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rfallen_in   = rfallen_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (ctrl.fire) begin
         unique case (ctrl.misc)
            MISC_FILT: begin
               filt_in = acc_ff[FILT_W+9:10];
            end
            MISC_SPEED: begin
               filt_in  = pfall_ff ? '0 : filt_ff;
               integ_in = pfall_ff ? '0 : integ_sat;
               se_in    = se_z;
               diff_in  = DIFF_W'(se_z) - DIFF_W'(last_ff);
            end
            MISC_OUT: begin
               last_in = LAST_W'(se_ff);
               if (fmode_ff == FWD_FORWARD) begin
                  integ_in = famt_q8;
               end else if (fmode_ff == FWD_BACKWARD) begin
                  integ_in = -famt_q8;
               end
               left_in      = sat_drive(left_pre);
               right_in     = sat_drive(right_pre);
               rfallen_in   = fallen_ff;
               rsp_valid_in = 1'b1;
            end
            default: begin
               filt_in = filt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff      <= '0;
         integ_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filt_ff      <= filt_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         err_ff    <= err_in;
         fallen_ff <= fallen_in;
         boost_ff  <= boost_in;
         pfall_ff  <= pfall_in;
         gyro_ff   <= gyro_in;
         tmode_ff  <= tmode_in;
         tamt_ff   <= tamt_in;
         fmode_ff  <= fmode_in;
         famt_ff   <= famt_in;
      end
      se_ff      <= se_in;
      diff_ff    <= diff_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      rfallen_ff <= rfallen_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_fallen      = rfallen_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/balance_cascade_pid.sv =====
// Top level of the balance cascade controller: register file, sequencer and datapath.
//
// One request is one control tick: pitch, gyro rate, both encoder counts and the
// turn and forward commands. One response follows each request: both wheel drives,
// saturated to +-8400, and the fallen flag.
// Request and response channels use valid/ready; a request is taken when req_valid
// and req_ready are both high. The csr_ port writes one gain or target register per
// cycle when csr_wr_en is high; write only while no request is in flight.
// rsp_valid rises when the microprogram has finished after the request is taken; it runs
// a longer path when the angle error is beyond the 18 degree boost threshold (the
// boosted gain needs a second pass through the shared multiplier). req_ready rises in
// the same cycle as rsp_valid, so a new request is taken only once the last one has run
// its whole microprogram on the single multiplier, which waits at its output step.
// A response waiting in the output register does not block the next request; a
// second response is held back until the receiver takes the first.
// Synchronous reset clears all gains and targets, the speed filter, integral and
// last speed error, and empties the output register.
`default_nettype none

module balance_cascade_pid
   import bcp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [16:0] req_pitch_angle,
   input  wire logic signed [19:0] req_gyro_rate,
   input  wire logic signed [15:0] req_left_count,
   input  wire logic signed [15:0] req_right_count,
   input  wire logic [1:0]         req_turn_mode,
   input  wire logic [13:0]        req_turn_amount,
   input  wire logic [1:0]         req_forward_mode,
   input  wire logic [15:0]        req_forward_amount,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [14:0]      rsp_left_drive,
   output logic signed [14:0]      rsp_right_drive,
   output logic                    rsp_fallen,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [16:0]        csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       start;
   ctrl_type   ctrl;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_ANGLE_TARGET: cfg_in.angle_target = csr_wdata[13:0];
            REG_ANGLE_P_GAIN: cfg_in.angle_p_gain = csr_wdata[15:0];
            REG_ANGLE_D_GAIN: cfg_in.angle_d_gain = csr_wdata[15:0];
            REG_SPEED_TARGET: cfg_in.speed_target = csr_wdata;
            REG_SPEED_P_GAIN: cfg_in.speed_p_gain = csr_wdata[15:0];
            REG_SPEED_I_GAIN: cfg_in.speed_i_gain = csr_wdata[15:0];
            REG_SPEED_D_GAIN: cfg_in.speed_d_gain = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bcp_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .start     (start),
      .status    (status),
      .ctrl      (ctrl)
   );

   bcp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .start              (start),
      .req_pitch_angle    (req_pitch_angle),
      .req_gyro_rate      (req_gyro_rate),
      .req_left_count     (req_left_count),
      .req_right_count    (req_right_count),
      .req_turn_mode      (req_turn_mode),
      .req_turn_amount    (req_turn_amount),
      .req_forward_mode   (req_forward_mode),
      .req_forward_amount (req_forward_amount),
      .ctrl               (ctrl),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_drive     (rsp_left_drive),
      .rsp_right_drive    (rsp_right_drive),
      .rsp_fallen         (rsp_fallen)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bcp_checker.sv =====
// Port-level checks for the balance cascade controller, bound to the top level.
`default_nettype none

module bcp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic signed [14:0] rsp_left_drive,
   input wire logic signed [14:0] rsp_right_drive,
   input wire logic              rsp_fallen
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive) && $stable(rsp_fallen))
      else $error("response changed while stalled");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_drive <= 15'sd8400) && (rsp_left_drive >= -15'sd8400)
         && (rsp_right_drive <= 15'sd8400) && (rsp_right_drive >= -15'sd8400))
      else $error("drive beyond saturation limit");

   a_fallen_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fallen |-> rsp_left_drive == rsp_right_drive)
      else $error("turn applied on a fallen tick");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind balance_cascade_pid bcp_checker u_bcp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_left_drive  (rsp_left_drive),
   .rsp_right_drive (rsp_right_drive),
   .rsp_fallen      (rsp_fallen)
);

`default_nettype wire
